/* design/imr_pkg.sv */
`timescale 1ns / 1ps

package imr_pkg;

    typedef enum logic [1:0] {
        KIND_WORD = 2'd0,
        KIND_POP  = 2'd1,
        KIND_TAKE = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IGNORED      = 4'd0,
        ST_ECHOED       = 4'd1,
        ST_ECHO_DROP    = 4'd2,
        ST_FORWARDED    = 4'd3,
        ST_PUSHED       = 4'd4,
        ST_PUSH_DROP    = 4'd5,
        ST_TOKEN_COUNT  = 4'd6,
        ST_POPPED       = 4'd7,
        ST_EMPTY        = 4'd8,
        ST_TOKEN_TAKEN  = 4'd9,
        ST_NO_TOKEN     = 4'd10
    } status_t;

    localparam int CMD_W       = 5;
    localparam int DATA_W      = 26;
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int TOKEN_W     = 4;
    localparam int USAGE_W     = 3;
    localparam int FLAG_POS    = 5;

    localparam logic [CMD_W-1:0]   CMD_NONE    = 5'd0;
    localparam logic [CMD_W-1:0]   MAILBOX_CMD = 5'd2;
    localparam logic [DATA_W-1:0]  TOKEN_DATA  = 26'd1;
    localparam logic [TOKEN_W-1:0] TOKEN_MAX   = 4'd15;

endpackage

/* design/imr_ram.sv */
`timescale 1ns / 1ps

module imr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/ipc_mailbox_receiver_core.sv */
`timescale 1ns / 1ps
// A request accepted from the item port sits in the input register; its result then
// goes to the result register. The ring RAM read port prefetches the head slot.
// Throughput: one request per cycle while the result stage is not stalled.
// Reset (rst_n low, async): indexes, token count, terminated flag, handler mask
// and both valid flags clear; ring contents are not cleared.
module ipc_mailbox_receiver_core #(
    parameter int RING_DEPTH  = 8,
    parameter int TOKEN_LIMIT = 7
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] word,
    input  logic        send_full,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [3:0]  status,
    output logic [31:0] send_word,
    output logic [7:0]  out_byte,
    output logic [4:0]  fwd_command,
    output logic [25:0] fwd_data,
    output logic        fwd_flag,
    output logic [2:0]  usage,
    output logic        terminated
);

    localparam int IW = $clog2(RING_DEPTH);
    localparam int UW = (IW + 1 > imr_pkg::USAGE_W) ? IW + 1 : imr_pkg::USAGE_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
    localparam logic [UW-1:0] DEPTH_U  = UW'(RING_DEPTH);
    localparam logic [imr_pkg::TOKEN_W-1:0] TOK_LIM = imr_pkg::TOKEN_W'(TOKEN_LIMIT);

    // configuration
    logic [31:0] handler_mask_reg;

    // input stage
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  kind_reg;
    logic [31:0] word_reg;
    logic        full_reg;

    // state
    logic [IW-1:0] wr_idx_reg, wr_idx_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [imr_pkg::TOKEN_W-1:0] tok_reg, tok_next;
    logic stopped_reg, stopped_next;

    // head-slot bypass for a write that lands on the slot being prefetched
    logic        byp_hit_reg, byp_hit_next;
    logic [7:0]  byp_data_reg;

    // result stage
    logic        result_valid_reg, result_valid_next;
    logic [3:0]  status_reg;
    logic [31:0] send_word_reg;
    logic [7:0]  out_byte_reg;
    logic [4:0]  fwd_command_reg;
    logic [25:0] fwd_data_reg;
    logic        fwd_flag_reg;
    logic [2:0]  usage_reg;
    logic        terminated_reg;

    // processing
    logic        advance;
    logic        load_in;
    logic [4:0]  cmd;
    logic        flag;
    logic [25:0] data;
    logic        registered;
    logic [IW-1:0] wr_inc, rd_inc;
    logic [IW-1:0] wr_calc, rd_calc;
    logic [imr_pkg::TOKEN_W-1:0] tok_calc, tok_sat;
    logic        stopped_calc;
    logic        push_en;
    imr_pkg::status_t st;
    logic [31:0] send_word_c;
    logic [7:0]  out_byte_c;
    logic [4:0]  fwd_command_c;
    logic [25:0] fwd_data_c;
    logic        fwd_flag_c;
    logic [UW-1:0] wr_u, rd_u, used_u;
    logic [7:0]  ram_rdata;
    logic [7:0]  head_byte;

    assign advance    = in_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign load_in    = item_valid && !item_stall;

    assign cmd  = word_reg[imr_pkg::CMD_W-1:0];
    assign flag = word_reg[imr_pkg::FLAG_POS];
    assign data = word_reg[31:6];
    assign registered = handler_mask_reg[cmd];

    assign wr_inc = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
    assign rd_inc = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
    assign tok_sat = (tok_reg == imr_pkg::TOKEN_MAX) ? tok_reg : tok_reg + 1'b1;
    assign head_byte = byp_hit_reg ? byp_data_reg : ram_rdata;

    always_comb
    begin
        st            = imr_pkg::ST_IGNORED;
        send_word_c   = '0;
        out_byte_c    = '0;
        fwd_command_c = '0;
        fwd_data_c    = '0;
        fwd_flag_c    = 1'b0;
        wr_calc       = wr_idx_reg;
        rd_calc       = rd_idx_reg;
        tok_calc      = tok_reg;
        stopped_calc  = stopped_reg;
        push_en       = 1'b0;
        case (kind_reg)
            imr_pkg::KIND_WORD:
            begin
                if (cmd != imr_pkg::CMD_NONE)
                begin
                    if (!registered)
                    begin
                        if (!flag)
                        begin
                            if (!full_reg)
                            begin
                                st = imr_pkg::ST_ECHOED;
                                send_word_c = word_reg;
                                send_word_c[imr_pkg::FLAG_POS] = 1'b1;
                            end
                            else
                            begin
                                st = imr_pkg::ST_ECHO_DROP;
                            end
                        end
                    end
                    else if (cmd == imr_pkg::MAILBOX_CMD)
                    begin
                        if (data != imr_pkg::TOKEN_DATA)
                        begin
                            if (wr_inc == rd_idx_reg)
                            begin
                                st = imr_pkg::ST_PUSH_DROP;
                            end
                            else
                            begin
                                st      = imr_pkg::ST_PUSHED;
                                push_en = 1'b1;
                                wr_calc = wr_inc;
                            end
                        end
                        else
                        begin
                            st       = imr_pkg::ST_TOKEN_COUNT;
                            tok_calc = tok_sat;
                            if (tok_sat > TOK_LIM)
                            begin
                                stopped_calc = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        st            = imr_pkg::ST_FORWARDED;
                        fwd_command_c = cmd;
                        fwd_data_c    = data;
                        fwd_flag_c    = flag;
                    end
                end
            end
            imr_pkg::KIND_POP:
            begin
                if (rd_idx_reg == wr_idx_reg)
                begin
                    st = imr_pkg::ST_EMPTY;
                end
                else
                begin
                    st         = imr_pkg::ST_POPPED;
                    out_byte_c = head_byte;
                    rd_calc    = rd_inc;
                end
            end
            imr_pkg::KIND_TAKE:
            begin
                if (tok_reg != '0)
                begin
                    st       = imr_pkg::ST_TOKEN_TAKEN;
                    tok_calc = tok_reg - 1'b1;
                end
                else
                begin
                    st = imr_pkg::ST_NO_TOKEN;
                end
            end
            default:
            begin
                st = imr_pkg::ST_IGNORED;
            end
        endcase
    end

    assign wr_idx_next  = advance ? wr_calc : wr_idx_reg;
    assign rd_idx_next  = advance ? rd_calc : rd_idx_reg;
    assign tok_next     = advance ? tok_calc : tok_reg;
    assign stopped_next = advance ? stopped_calc : stopped_reg;
    assign byp_hit_next = advance && push_en && (wr_idx_reg == rd_idx_next);

    // usage after this step, from the updated indexes
    assign wr_u   = UW'(wr_calc);
    assign rd_u   = UW'(rd_calc);
    assign used_u = (wr_u >= rd_u) ? wr_u - rd_u : wr_u + DEPTH_U - rd_u;

    assign in_valid_next = load_in ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign result_valid_next = advance ? 1'b1 :
                               (result_stall ? result_valid_reg : 1'b0);

    imr_ram #(
        .WIDTH (imr_pkg::BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (advance && push_en),
        .waddr (wr_idx_reg),
        .wdata (data[7:0]),
        .raddr (rd_idx_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handler_mask_reg <= '0;
            in_valid_reg     <= 1'b0;
            wr_idx_reg       <= '0;
            rd_idx_reg       <= '0;
            tok_reg          <= '0;
            stopped_reg      <= 1'b0;
            byp_hit_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            terminated_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                handler_mask_reg <= cfg_wdata;
            end
            in_valid_reg     <= in_valid_next;
            wr_idx_reg       <= wr_idx_next;
            rd_idx_reg       <= rd_idx_next;
            tok_reg          <= tok_next;
            stopped_reg      <= stopped_next;
            byp_hit_reg      <= byp_hit_next;
            result_valid_reg <= result_valid_next;
            if (advance)
            begin
                terminated_reg <= stopped_calc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            kind_reg <= kind;
            word_reg <= word;
            full_reg <= send_full;
        end
        byp_data_reg <= data[7:0];
        if (advance)
        begin
            status_reg      <= st;
            send_word_reg   <= send_word_c;
            out_byte_reg    <= out_byte_c;
            fwd_command_reg <= fwd_command_c;
            fwd_data_reg    <= fwd_data_c;
            fwd_flag_reg    <= fwd_flag_c;
            usage_reg       <= used_u[imr_pkg::USAGE_W-1:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign send_word    = send_word_reg;
    assign out_byte     = out_byte_reg;
    assign fwd_command  = fwd_command_reg;
    assign fwd_data     = fwd_data_reg;
    assign fwd_flag     = fwd_flag_reg;
    assign usage        = usage_reg;
    assign terminated   = terminated_reg;

endmodule

/* design/imr_checker.sv */
`timescale 1ns / 1ps

module imr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic [3:0]  status,
    input logic [31:0] send_word,
    input logic [7:0]  out_byte,
    input logic [2:0]  usage,
    input logic        terminated
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(status) && $stable(out_byte) && $stable(usage))
        else $error("stalled result changed");

    // terminated is sticky
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && terminated |=> terminated)
        else $error("terminated flag cleared");

    // an empty pop leaves the ring empty
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == imr_pkg::ST_EMPTY |-> usage == 3'd0)
        else $error("empty pop with nonzero usage");

    // out_byte only carries data for a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != imr_pkg::ST_POPPED |-> out_byte == 8'd0)
        else $error("out_byte set without pop");

    // echo always carries the reply flag
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == imr_pkg::ST_ECHOED |-> send_word[5])
        else $error("echo without reply flag");

endmodule

bind ipc_mailbox_receiver_core imr_checker u_imr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .send_word    (send_word),
    .out_byte     (out_byte),
    .usage        (usage),
    .terminated   (terminated)
);

/* tb/sv/imr_reply_checker.sv */
`timescale 1ns / 1ps

module imr_reply_checker
    import imr_pkg::*;
#(
    parameter int RING_DEPTH  = 8,
    parameter int TOKEN_LIMIT = 7
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,

    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] word,
    input  logic        send_full,

    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [3:0]  status,
    input  logic [31:0] send_word,
    input  logic [7:0]  out_byte,
    input  logic [4:0]  fwd_command,
    input  logic [25:0] fwd_data,
    input  logic        fwd_flag,
    input  logic [2:0]  usage,
    input  logic        terminated,

    output int          mismatches,
    output int          pending
);

    typedef struct {
        status_t               status;
        logic [WORD_W-1:0]     send_word;
        logic [BYTE_W-1:0]     out_byte;
        logic [CMD_W-1:0]      fwd_command;
        logic [DATA_W-1:0]     fwd_data;
        logic                  fwd_flag;
        logic [USAGE_W-1:0]    usage;
        logic                  terminated;
    } mbox_reply_t;

    // shadow of the receiver state
    logic [31:0]        handler_mask = '0;
    logic [BYTE_W-1:0]  ring_bytes [RING_DEPTH];
    int                 wr_idx = 0;
    int                 rd_idx = 0;
    logic [TOKEN_W-1:0] tokens = '0;
    logic               stopped = 1'b0;

    mbox_reply_t        replies_due [$];
    int                 mismatch_cnt = 0;
    int                 pending_cnt = 0;

    assign mismatches = mismatch_cnt;
    assign pending    = pending_cnt;

    function automatic mbox_reply_t predict_reply(logic [1:0] k, logic [31:0] w, logic full);
        mbox_reply_t       r;
        logic [CMD_W-1:0]  cmd;
        logic              flag;
        logic [DATA_W-1:0] data;
        int                nxt;
        r.status      = ST_IGNORED;
        r.send_word   = '0;
        r.out_byte    = '0;
        r.fwd_command = '0;
        r.fwd_data    = '0;
        r.fwd_flag    = 1'b0;
        cmd  = w[CMD_W-1:0];
        flag = w[FLAG_POS];
        data = w[WORD_W-1:FLAG_POS+1];
        case (k)
            KIND_WORD:
            begin
                if (cmd != CMD_NONE)
                begin
                    if (!handler_mask[cmd])
                    begin
                        // unregistered with reply flag set is silently ignored
                        if (!flag)
                        begin
                            if (!full)
                            begin
                                r.status    = ST_ECHOED;
                                r.send_word = w | (32'd1 << FLAG_POS);
                            end
                            else
                                r.status = ST_ECHO_DROP;
                        end
                    end
                    else if (cmd == MAILBOX_CMD)
                    begin
                        if (data != TOKEN_DATA)
                        begin
                            nxt = (wr_idx + 1) % RING_DEPTH;
                            if (nxt == rd_idx)
                                r.status = ST_PUSH_DROP;
                            else
                            begin
                                ring_bytes[wr_idx] = data[BYTE_W-1:0];
                                wr_idx   = nxt;
                                r.status = ST_PUSHED;
                            end
                        end
                        else
                        begin
                            if (tokens != TOKEN_MAX)
                                tokens = tokens + 1'b1;
                            if (tokens > TOKEN_LIMIT)
                                stopped = 1'b1;
                            r.status = ST_TOKEN_COUNT;
                        end
                    end
                    else
                    begin
                        r.status      = ST_FORWARDED;
                        r.fwd_command = cmd;
                        r.fwd_data    = data;
                        r.fwd_flag    = flag;
                    end
                end
            end
            KIND_POP:
            begin
                if (rd_idx == wr_idx)
                    r.status = ST_EMPTY;
                else
                begin
                    r.out_byte = ring_bytes[rd_idx];
                    rd_idx     = (rd_idx + 1) % RING_DEPTH;
                    r.status   = ST_POPPED;
                end
            end
            KIND_TAKE:
            begin
                if (tokens != '0)
                begin
                    tokens   = tokens - 1'b1;
                    r.status = ST_TOKEN_TAKEN;
                end
                else
                    r.status = ST_NO_TOKEN;
            end
            default:
            begin
            end
        endcase
        r.usage      = USAGE_W'((wr_idx + RING_DEPTH - rd_idx) % RING_DEPTH);
        r.terminated = stopped;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_v, got_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        mbox_reply_t exp_r;
        if (!rst_n)
        begin
            handler_mask = '0;
            wr_idx       = 0;
            rd_idx       = 0;
            tokens       = '0;
            stopped      = 1'b0;
            replies_due.delete();
            pending_cnt <= 0;
        end
        else
        begin
            if (cfg_we)
                handler_mask = cfg_wdata;
            if (item_valid && !item_stall)
                replies_due.push_back(predict_reply(kind, word, send_full));
            if (result_valid && !result_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d", $realtime, status);
                    mismatch_cnt++;
                end
                else
                begin
                    exp_r = replies_due.pop_front();
                    check_field("status", 32'(exp_r.status), 32'(status));
                    check_field("send_word", exp_r.send_word, send_word);
                    check_field("out_byte", 32'(exp_r.out_byte), 32'(out_byte));
                    check_field("fwd_command", 32'(exp_r.fwd_command), 32'(fwd_command));
                    check_field("fwd_data", 32'(exp_r.fwd_data), 32'(fwd_data));
                    check_field("fwd_flag", 32'(exp_r.fwd_flag), 32'(fwd_flag));
                    check_field("usage", 32'(exp_r.usage), 32'(usage));
                    check_field("terminated", 32'(exp_r.terminated), 32'(terminated));
                end
            end
            pending_cnt <= replies_due.size();
        end
    end

    final
    begin
    end

endmodule

/* tb/sv/tb_ipc_mailbox_receiver_core.sv */
`timescale 1ns / 1ps

module tb_ipc_mailbox_receiver_core;
    import imr_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 150;
    localparam int SETTLE_CYCLES = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [1:0]  kind = '0;
    logic [31:0] word = '0;
    logic        send_full = 1'b0;

    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [3:0]  status;
    logic [31:0] send_word;
    logic [7:0]  out_byte;
    logic [4:0]  fwd_command;
    logic [25:0] fwd_data;
    logic        fwd_flag;
    logic [2:0]  usage;
    logic        terminated;

    int          mismatches;
    int          pending;
    int          sent = 0;
    int          quiet_cycles = 0;
    logic        jitter_on = 1'b1;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    ipc_mailbox_receiver_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .word         (word),
        .send_full    (send_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .send_word    (send_word),
        .out_byte     (out_byte),
        .fwd_command  (fwd_command),
        .fwd_data     (fwd_data),
        .fwd_flag     (fwd_flag),
        .usage        (usage),
        .terminated   (terminated)
    );

    imr_reply_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .word         (word),
        .send_full    (send_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .send_word    (send_word),
        .out_byte     (out_byte),
        .fwd_command  (fwd_command),
        .fwd_data     (fwd_data),
        .fwd_flag     (fwd_flag),
        .usage        (usage),
        .terminated   (terminated),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        result_stall <= jitter_on && ($urandom_range(0, 99) < 18);
    end

    // nothing accepted on either side for too long means a hang
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL ipc_mailbox_receiver_core");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] k, input logic [31:0] w, input logic full);
        while (jitter_on && ($urandom_range(0, 99) < 18))
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= k;
        word       <= w;
        send_full  <= full;
        do
            @(posedge clk);
        while (item_stall);
        if (k != 2'd3)
            sent++;
    endtask

    // hold requests back until every reply is in, then let the pipe settle
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask(input logic [31:0] m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] mailbox_word(logic [25:0] d, logic flag);
        return {d, flag, MAILBOX_CMD};
    endfunction

    task automatic random_burst();
        int          sel;
        int          n;
        logic [31:0] w;
        sel = $urandom_range(0, 99);
        if (sel < 35)
        begin
            n = $urandom_range(1, 9);
            repeat (n) send_item(KIND_WORD, mailbox_word(26'($urandom), 1'($urandom)),
                                 1'($urandom));
        end
        else if (sel < 55)
        begin
            n = $urandom_range(1, 9);
            repeat (n) send_item(KIND_POP, $urandom, 1'($urandom));
        end
        else if (sel < 70)
        begin
            // long runs reach the limit and saturate the counter
            n = $urandom_range(1, 17);
            repeat (n) send_item(KIND_WORD, mailbox_word(TOKEN_DATA, 1'($urandom)),
                                 1'($urandom));
        end
        else if (sel < 80)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_item(KIND_TAKE, $urandom, 1'($urandom));
        end
        else if (sel < 97)
        begin
            w = $urandom;
            if ($urandom_range(0, 2) == 0)
                w[CMD_W-1:0] = CMD_W'($urandom_range(0, 5));
            send_item(KIND_WORD, w, 1'($urandom));
        end
        else
            send_item(2'd3, $urandom, 1'($urandom));
    endtask

    initial
    begin
        logic [31:0] masks [5];
        logic [25:0] d;
        int          target;
        masks[0] = 32'hFFFF_FFFF;
        masks[1] = 32'h0000_0000;
        masks[2] = 32'h0000_0004;
        masks[3] = $urandom | 32'h0000_0004;
        masks[4] = $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // mailbox, cmd 4 and cmd 31 registered
        write_mask(32'h8000_0014);
        send_item(KIND_WORD, 32'h0000_0000, 1'b0);
        send_item(KIND_WORD, 32'hFFFF_FFC0, 1'b1);
        send_item(KIND_WORD, {26'h2AA_AAAA, 1'b0, 5'd1}, 1'b0);
        send_item(KIND_WORD, {26'h2AA_AAAA, 1'b0, 5'd1}, 1'b1);
        send_item(KIND_WORD, {26'h155_5555, 1'b1, 5'd3}, 1'b0);
        send_item(KIND_WORD, {26'h3FF_FFFF, 1'b1, 5'd4}, 1'b1);
        send_item(KIND_WORD, {26'h000_0000, 1'b0, 5'd31}, 1'b0);
        send_item(KIND_POP, 32'hFFFF_FFFF, 1'b0);
        send_item(KIND_TAKE, 32'h0000_0000, 1'b1);
        send_item(2'd3, 32'hFFFF_FFFF, 1'b1);
        // fill the ring, last push finds it full
        for (int i = 0; i < 8; i++)
        begin
            d = (i == 0) ? 26'h3FF_FFFF : (i == 1) ? 26'h0 : 26'h100 + 26'(i);
            send_item(KIND_WORD, mailbox_word(d, 1'(i)), 1'(i));
        end
        send_item(KIND_POP, 32'h0, 1'b0);
        send_item(KIND_POP, 32'h0, 1'b1);
        send_item(KIND_WORD, mailbox_word(TOKEN_DATA, 1'b0), 1'b0);
        send_item(KIND_WORD, mailbox_word(TOKEN_DATA, 1'b1), 1'b1);
        send_item(KIND_TAKE, 32'h0, 1'b0);
        send_item(KIND_POP, 32'h0, 1'b0);

        for (int p = 0; p < 5; p++)
        begin
            drain();
            write_mask(masks[p]);
            jitter_on <= (p != 2);
            target = sent + PHASE_ITEMS;
            while (sent < target)
                random_burst();
        end

        drain();
        if (mismatches == 0)
            $display("PASS ipc_mailbox_receiver_core");
        else
            $display("FAIL ipc_mailbox_receiver_core");
        $finish;
    end

endmodule

/* filelist.f */
design/imr_pkg.sv
design/imr_ram.sv
design/ipc_mailbox_receiver_core.sv
design/imr_checker.sv
tb/sv/imr_reply_checker.sv
tb/sv/tb_ipc_mailbox_receiver_core.sv
